// ===== sv/sbh_pkg.sv =====
// Shared types, codes and constants for the SHA-1 byte stream hasher.
`default_nettype none
package sbh_pkg;

  // Input command codes
  localparam logic [1:0] CMD_ABSORB     = 2'd0;
  localparam logic [1:0] CMD_ABSORB_FIN = 2'd1;
  localparam logic [1:0] CMD_FINISH     = 2'd2;

  localparam logic [7:0] MARK_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] POS_LAST   = 6'd63;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD  = 3'd4;
  localparam int         NUM_WORDS  = 5;
  localparam int         BLK_BYTES  = 64;

  localparam logic [31:0] IV [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } sbh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sbh_out_t;

  // Source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } sbh_src_t;

  // Round group: selects the mixing function and round constant
  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } sbh_phase_t;

  typedef struct packed {
    logic       shift_byte;
    sbh_src_t   byte_sel;
    logic       count;
    logic       round_en;
    logic       w_load;
    sbh_phase_t phase;
    logic       add_en;
    logic       init;
    logic [2:0] widx;
  } sbh_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } sbh_stat_t;

  function automatic logic [31:0] round_k(input sbh_phase_t ph);
    logic [31:0] k;
    unique case (ph)
      PH_CH:   k = 32'h5A827999;
      PH_PAR1: k = 32'h6ED9EBA1;
      PH_MAJ:  k = 32'h8F1BBCDC;
      PH_PAR2: k = 32'hCA62C1D6;
      default: k = 32'h5A827999;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sbh_datapath.sv =====
// Datapath: block buffer / schedule shift line, round logic, chaining words, bit count.
`default_nettype none
module sbh_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       data_byte,
  input  wire sbh_pkg::sbh_cmd_t cmd,
  output sbh_pkg::sbh_stat_t    stat,
  output sbh_pkg::sbh_out_t     out_item
);
  import sbh_pkg::*;

  logic [7:0]  blk [BLK_BYTES];
  logic [31:0] chain [NUM_WORDS];
  logic [31:0] work [NUM_WORDS];
  logic [31:0] sum [NUM_WORDS];
  logic [63:0] bit_count;
  logic [5:0]  pos;

  logic [7:0]  byte_in;
  logic [7:0]  len_byte;
  logic [2:0]  len_idx;
  logic [31:0] w0, w2, w8, w13, wx, w;
  logic [31:0] f, b, c, d, tmp;

  always_comb begin
    len_idx  = ~pos[2:0];
    len_byte = bit_count[8*len_idx +: 8];
    unique case (cmd.byte_sel)
      SRC_DATA: byte_in = data_byte;
      SRC_MARK: byte_in = MARK_BYTE;
      SRC_ZERO: byte_in = 8'h00;
      SRC_LEN:  byte_in = len_byte;
      default:  byte_in = 8'h00;
    endcase
  end

  // Schedule taps: word 0 is W[t-16], 2 is W[t-14], 8 is W[t-8], 13 is W[t-3]
  always_comb begin
    w0  = {blk[0],  blk[1],  blk[2],  blk[3]};
    w2  = {blk[8],  blk[9],  blk[10], blk[11]};
    w8  = {blk[32], blk[33], blk[34], blk[35]};
    w13 = {blk[52], blk[53], blk[54], blk[55]};
    wx  = w13 ^ w8 ^ w2 ^ w0;
    w   = cmd.w_load ? w0 : {wx[30:0], wx[31]};
  end

  always_comb begin
    b = work[1];
    c = work[2];
    d = work[3];
    unique case (cmd.phase)
      PH_CH:   f = (b & c) | (~b & d);
      PH_MAJ:  f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    tmp = {work[0][26:0], work[0][31:27]} + f + work[4] + round_k(cmd.phase) + w;
    for (int i = 0; i < NUM_WORDS; i++) begin
      sum[i] = chain[i] + work[i];
    end
  end

  // Buffer holds raw message bytes, then serves as the schedule ring
  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      for (int i = 0; i < BLK_BYTES - 1; i++) begin
        blk[i] <= blk[i+1];
      end
      blk[BLK_BYTES-1] <= byte_in;
    end else if (cmd.round_en) begin
      for (int i = 0; i < BLK_BYTES - 4; i++) begin
        blk[i] <= blk[i+4];
      end
      blk[BLK_BYTES-4] <= w[31:24];
      blk[BLK_BYTES-3] <= w[23:16];
      blk[BLK_BYTES-2] <= w[15:8];
      blk[BLK_BYTES-1] <= w[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain[i] <= IV[i];
        work[i]  <= IV[i];
      end
      bit_count <= '0;
      pos       <= '0;
    end else begin
      if (cmd.shift_byte) begin
        pos <= pos + 6'd1;
      end
      if (cmd.count) begin
        bit_count <= bit_count + 64'd8;
      end
      if (cmd.round_en) begin
        work[0] <= tmp;
        work[1] <= work[0];
        work[2] <= {work[1][1:0], work[1][31:2]};
        work[3] <= work[2];
        work[4] <= work[3];
      end
      if (cmd.add_en) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          chain[i] <= sum[i];
          work[i]  <= sum[i];
        end
      end
      if (cmd.init) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          chain[i] <= IV[i];
          work[i]  <= IV[i];
        end
        bit_count <= '0;
      end
    end
  end

  assign stat.pos             = pos;
  assign out_item.digest_word = chain[cmd.widx];
  assign out_item.word_index  = cmd.widx;
  assign out_item.last_word   = (cmd.widx == LAST_WORD);

endmodule
`default_nettype wire

// ===== sv/sbh_ctrl.sv =====
// Controller: sequences absorb, padding, 80 rounds, chain update and digest beats.
`default_nettype none
module sbh_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_ready,
  input  wire logic [1:0]         cmd_code,
  output logic                    digest_valid,
  input  wire logic               digest_ready,
  input  wire sbh_pkg::sbh_stat_t stat,
  output sbh_pkg::sbh_cmd_t       cmd
);
  import sbh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_EMIT
  } state_t;

  state_t     state;
  logic [6:0] rnd;
  logic       fin;
  logic       marked;
  logic       len_ok;
  logic       last_blk;
  logic [2:0] widx;

  logic is_absorb;

  assign is_absorb = (cmd_code == CMD_ABSORB) || (cmd_code == CMD_ABSORB_FIN);

  always_comb begin
    cmd.shift_byte = 1'b0;
    cmd.byte_sel   = SRC_DATA;
    cmd.count      = 1'b0;
    cmd.round_en   = 1'b0;
    cmd.w_load     = (rnd < 7'd16);
    cmd.add_en     = 1'b0;
    cmd.init       = 1'b0;
    cmd.widx       = widx;
    if (rnd < 7'd20) begin
      cmd.phase = PH_CH;
    end else if (rnd < 7'd40) begin
      cmd.phase = PH_PAR1;
    end else if (rnd < 7'd60) begin
      cmd.phase = PH_MAJ;
    end else begin
      cmd.phase = PH_PAR2;
    end
    byte_ready   = (state == S_IDLE);
    digest_valid = (state == S_EMIT);
    unique case (state)
      S_IDLE: begin
        if (byte_valid && is_absorb) begin
          cmd.shift_byte = 1'b1;
          cmd.count      = 1'b1;
        end
      end
      S_PAD: begin
        cmd.shift_byte = 1'b1;
        if (!marked) begin
          cmd.byte_sel = SRC_MARK;
        end else if (stat.pos >= LEN_POS && len_ok) begin
          cmd.byte_sel = SRC_LEN;
        end else begin
          cmd.byte_sel = SRC_ZERO;
        end
      end
      S_ROUND: cmd.round_en = 1'b1;
      S_ADD:   cmd.add_en = 1'b1;
      S_EMIT: begin
        if (digest_ready && widx == LAST_WORD) begin
          cmd.init = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rnd      <= '0;
      fin      <= 1'b0;
      marked   <= 1'b0;
      len_ok   <= 1'b0;
      last_blk <= 1'b0;
      widx     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (byte_valid) begin
            if (is_absorb) begin
              fin      <= (cmd_code == CMD_ABSORB_FIN);
              marked   <= 1'b0;
              last_blk <= 1'b0;
              if (stat.pos == POS_LAST) begin
                state <= S_ROUND;
              end else if (cmd_code == CMD_ABSORB_FIN) begin
                state <= S_PAD;
              end
            end else if (cmd_code == CMD_FINISH) begin
              fin    <= 1'b1;
              marked <= 1'b0;
              state  <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (!marked) begin
            marked <= 1'b1;
            len_ok <= (stat.pos < LEN_POS);
          end
          if (stat.pos == POS_LAST) begin
            last_blk <= marked && len_ok;
            state    <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (rnd == LAST_ROUND) begin
            rnd   <= '0;
            state <= S_ADD;
          end else begin
            rnd <= rnd + 7'd1;
          end
        end
        S_ADD: begin
          if (!fin) begin
            state <= S_IDLE;
          end else if (last_blk) begin
            widx  <= '0;
            state <= S_EMIT;
          end else begin
            // marker spilled past the length slot: next block carries the length
            len_ok <= 1'b1;
            state  <= S_PAD;
          end
        end
        S_EMIT: begin
          if (digest_ready) begin
            if (widx == LAST_WORD) begin
              fin   <= 1'b0;
              state <= S_IDLE;
            end else begin
              widx <= widx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/sha1_byte_stream_hasher.sv =====
// Top level: SHA-1 over a byte stream, one byte beat in, five digest word beats out.
// Operation: an absorb beat shifts one byte in; the beat that fills a 64-byte block
//   starts 80 rounds, one per cycle, then the chaining-word add. Finish: padding bytes
//   enter one per cycle to the block end, then rounds and add run per padded block (one
//   or two), then five digest beats, H0 first, each one waiting for digest_ready.
// Reset (rst, synchronous) loads H0..H4, clears bit count and fill position, not buffer.
`default_nettype none
module sha1_byte_stream_hasher (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             byte_valid,
  output logic                  byte_ready,
  input  wire sbh_pkg::sbh_in_t byte_item,
  output logic                  digest_valid,
  input  wire logic             digest_ready,
  output sbh_pkg::sbh_out_t     digest_item
);
  import sbh_pkg::*;

  sbh_cmd_t  cmd;
  sbh_stat_t stat;

  // Controller: accepts beats only when idle, then sequences padding and rounds
  sbh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .cmd_code     (byte_item.cmd),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Datapath: chaining words hold steady while digest beats are offered
  sbh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .data_byte (byte_item.data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (digest_item)
  );

endmodule
`default_nettype wire
